// File: design/slcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared constants and the keyword compare for the serial line command decoder.
// ----------------------------------------------------------------------------
package slcd_pkg;

	localparam int LINE_LENGTH = 32;
	localparam int FILL_W      = $clog2(LINE_LENGTH + 1);
	localparam int ADDR_W      = $clog2(LINE_LENGTH);

	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_BS  = 8'h7f;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam int KW_CHARS = 5;

	localparam logic [8*KW_CHARS-1:0] KW_DEBUG = "debug";
	localparam logic [8*KW_CHARS-1:0] KW_RELAY = "relay";
	localparam logic [8*KW_CHARS-1:0] KW_PWM   = {"pwm", 16'h0000};
	localparam logic [8*KW_CHARS-1:0] KW_ON    = {"on", 24'h000000};
	localparam logic [8*KW_CHARS-1:0] KW_OFF   = {"off", 16'h0000};

	localparam logic [2:0] LEN_DEBUG = 3'd5;
	localparam logic [2:0] LEN_RELAY = 3'd5;
	localparam logic [2:0] LEN_PWM   = 3'd3;
	localparam logic [2:0] LEN_ON    = 3'd2;
	localparam logic [2:0] LEN_OFF   = 3'd3;

	// True when c equals the keyword character at position pos.
	function automatic logic kw_hit(
		input logic [8*KW_CHARS-1:0] kw,
		input logic [2:0]            kw_len,
		input logic [2:0]            pos,
		input logic [7:0]            c
	);
		logic [7:0] k;
		k = CH_NUL;
		for (int j = 0; j < KW_CHARS; j++) begin
			if (3'(j) == pos) begin
				k = kw[8*(KW_CHARS-1-j) +: 8];
			end
		end
		return (pos < kw_len) && (c == k);
	endfunction

endpackage

`default_nettype wire

// File: design/serial_line_command_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_command_decoder
// Collects received bytes into a line and runs "debug", "relay" and "pwm"
// on/off commands at each line end.
//
// Input channel: one rx_byte word per in_valid/in_ready handshake. Output
// channel: one result word per input word, carrying the debug flag, the
// relay and pwm enable levels, and line_executed for a byte that ended a line.
// A stored byte or a backspace goes straight to the emit state. A line
// end (CR, LF, or the byte that fills the 32-byte store) scans the store one
// byte per cycle through the RAM read port and one comparator per keyword,
// and the scan stops early at the first NUL byte that it reads.
// in_ready is high only while the block is idle. A result waits in the output
// register until out_ready; the block accepts the next byte meanwhile and
// holds its own result until the register frees.
// Reset clears the fill count, the flags and both pins; the store itself is
// never cleared, since only entries below the fill count are read.
// ----------------------------------------------------------------------------
module serial_line_command_decoder
	import slcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            debug_on,
	output logic            relay_on,
	output logic            pwm_enable_on,
	output logic            line_executed
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_W1,
		PH_GAP,
		PH_W2,
		PH_TAIL
	} phase_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   end_q;
	logic [FILL_W-1:0]   idx_q;
	logic                rd_valid_s1;
	logic                stop_q;
	logic [2:0]          wlen_q;
	logic [2:0]          m1_q;
	logic [1:0]          m2_q;
	logic [2:0]          cmd_q;
	logic                have_w2_q;
	logic                debug_q;
	logic                relay_q;
	logic                pwm_q;
	logic                exec_q;

	logic                accept;
	logic                is_eol;
	logic                is_bs;
	logic                ram_we;
	logic [7:0]          rd_data;
	logic                proc;
	logic                is_sp;
	logic                zero_now;
	logic                issue;
	logic                scan_done;
	logic [2:0]          wlen_inc;
	logic                on_hit;
	logic                off_hit;
	logic                arg_ok;
	logic                emit;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_eol    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign is_bs     = (rx_byte == CH_BS);
	assign ram_we    = accept && !is_eol && !is_bs;

	slcd_ram #(
		.WIDTH (8),
		.DEPTH (LINE_LENGTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (rx_byte),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	assign proc      = rd_valid_s1 && !stop_q;
	assign is_sp     = (rd_data == CH_SP);
	assign zero_now  = proc && (rd_data == CH_NUL);
	assign issue     = (state_q == ST_SCAN) && !stop_q && !zero_now && (idx_q != end_q);
	assign scan_done = !rd_valid_s1 && (stop_q || (idx_q == end_q));
	assign wlen_inc  = (wlen_q == 3'd7) ? wlen_q : wlen_q + 3'd1;
	assign on_hit    = m2_q[0] && (wlen_q == LEN_ON);
	assign off_hit   = m2_q[1] && (wlen_q == LEN_OFF);
	assign arg_ok    = have_w2_q && (on_hit || off_hit);
	assign emit      = (state_q == ST_EMIT) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_LEAD;
			fill_q        <= '0;
			end_q         <= '0;
			idx_q         <= '0;
			rd_valid_s1   <= 1'b0;
			stop_q        <= 1'b0;
			wlen_q        <= '0;
			m1_q          <= '0;
			m2_q          <= '0;
			cmd_q         <= '0;
			have_w2_q     <= 1'b0;
			debug_q       <= 1'b0;
			relay_q       <= 1'b0;
			pwm_q         <= 1'b0;
			exec_q        <= 1'b0;
			out_valid     <= 1'b0;
			debug_on      <= 1'b0;
			relay_on      <= 1'b0;
			pwm_enable_on <= 1'b0;
			line_executed <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						exec_q      <= 1'b0;
						idx_q       <= '0;
						rd_valid_s1 <= 1'b0;
						stop_q      <= 1'b0;
						phase_q     <= PH_LEAD;
						have_w2_q   <= 1'b0;
						cmd_q       <= '0;
						if (is_eol) begin
							end_q   <= fill_q;
							state_q <= ST_SCAN;
						end else if (is_bs) begin
							if (fill_q != '0) begin
								fill_q <= fill_q - FILL_W'(1);
							end
							state_q <= ST_EMIT;
						end else begin
							fill_q <= fill_q + FILL_W'(1);
							if (fill_q == FILL_W'(LINE_LENGTH - 1)) begin
								end_q   <= FILL_W'(LINE_LENGTH);
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_SCAN: begin
					rd_valid_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + FILL_W'(1);
					end
					if (zero_now) begin
						stop_q <= 1'b1;
					end else if (proc) begin
						case (phase_q)
							PH_LEAD: begin
								if (!is_sp) begin
									phase_q <= PH_W1;
									wlen_q  <= 3'd1;
									m1_q    <= {kw_hit(KW_PWM, LEN_PWM, 3'd0, rd_data),
										kw_hit(KW_RELAY, LEN_RELAY, 3'd0, rd_data),
										kw_hit(KW_DEBUG, LEN_DEBUG, 3'd0, rd_data)};
								end
							end
							PH_W1: begin
								if (is_sp) begin
									phase_q <= PH_GAP;
									cmd_q   <= {m1_q[2] && (wlen_q == LEN_PWM),
										m1_q[1] && (wlen_q == LEN_RELAY),
										m1_q[0] && (wlen_q == LEN_DEBUG)};
								end else begin
									wlen_q <= wlen_inc;
									m1_q   <= m1_q & {kw_hit(KW_PWM, LEN_PWM, wlen_q, rd_data),
										kw_hit(KW_RELAY, LEN_RELAY, wlen_q, rd_data),
										kw_hit(KW_DEBUG, LEN_DEBUG, wlen_q, rd_data)};
								end
							end
							PH_GAP: begin
								if (!is_sp) begin
									phase_q   <= PH_W2;
									have_w2_q <= 1'b1;
									wlen_q    <= 3'd1;
									m2_q      <= {kw_hit(KW_OFF, LEN_OFF, 3'd0, rd_data),
										kw_hit(KW_ON, LEN_ON, 3'd0, rd_data)};
								end
							end
							PH_W2: begin
								if (is_sp) begin
									phase_q <= PH_TAIL;
								end else begin
									wlen_q <= wlen_inc;
									m2_q   <= m2_q & {kw_hit(KW_OFF, LEN_OFF, wlen_q, rd_data),
										kw_hit(KW_ON, LEN_ON, wlen_q, rd_data)};
								end
							end
							default: begin
							end
						endcase
					end
					if (scan_done) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (arg_ok) begin
						if (cmd_q[0]) begin
							debug_q <= on_hit;
						end else if (cmd_q[1] && debug_q) begin
							relay_q <= on_hit;
						end else if (cmd_q[2] && debug_q) begin
							pwm_q <= on_hit;
						end
					end
					fill_q  <= '0;
					exec_q  <= 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						debug_on      <= debug_q;
						relay_on      <= relay_q;
						pwm_enable_on <= pwm_q;
						line_executed <= exec_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/slcd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slcd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module slcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: dv/serial_line_command_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_command_decoder_test
// Feeds received bytes to the decoder and predicts the debug flag, the relay
// and pwm pin levels and the line end mark for every byte. Lines are mostly
// well-formed commands with random spacing, typos and arguments, mixed with
// raw noise. Sender gaps and receiver stalls vary by phase, and one long
// receiver hold fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module serial_line_command_decoder_test
	import slcd_pkg::*;
();

	typedef struct packed {
		logic dbg;
		logic relay;
		logic pwm;
		logic executed;
	} decoder_status_t;

	localparam int HOLD_CYCLES = 400;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       debug_on;
	logic       relay_on;
	logic       pwm_enable_on;
	logic       line_executed;

	logic [7:0]      line_buf [LINE_LENGTH];
	int              line_fill = 0;
	logic            dbg_flag  = 1'b0;
	logic            relay_lvl = 1'b0;
	logic            pwm_lvl   = 1'b0;
	decoder_status_t expected_status [$];
	logic [7:0]      line_bytes [$];

	int idle_pct    = 0;
	int stall_pct   = 0;
	bit hold_req    = 1'b0;
	int hold_left   = 0;
	int error_count = 0;

	serial_line_command_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.debug_on      (debug_on),
		.relay_on      (relay_on),
		.pwm_enable_on (pwm_enable_on),
		.line_executed (line_executed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic bit word_matches(input int start, input int len, input string kw);
		if (len != kw.len()) return 1'b0;
		for (int j = 0; j < len; j++) begin
			if (line_buf[start + j] != kw[j]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void evaluate_command_line();
		int stop, pos, s1, l1, s2, l2, arg;
		pos = 0;
		while (pos < line_fill && line_buf[pos] != CH_NUL) pos++;
		stop = pos;
		pos = 0;
		while (pos < stop && line_buf[pos] == CH_SP) pos++;
		s1 = pos;
		while (pos < stop && line_buf[pos] != CH_SP) pos++;
		l1 = pos - s1;
		while (pos < stop && line_buf[pos] == CH_SP) pos++;
		s2 = pos;
		while (pos < stop && line_buf[pos] != CH_SP) pos++;
		l2 = pos - s2;
		if (l2 > 0) begin
			arg = word_matches(s2, l2, "on") ? 1 : (word_matches(s2, l2, "off") ? 0 : -1);
			if (word_matches(s1, l1, "debug")) begin
				if (arg >= 0) dbg_flag = arg[0];
			end else if (word_matches(s1, l1, "relay")) begin
				if (dbg_flag && arg >= 0) relay_lvl = arg[0];
			end else if (word_matches(s1, l1, "pwm")) begin
				if (dbg_flag && arg >= 0) pwm_lvl = arg[0];
			end
		end
		line_fill = 0;
	endfunction

	function automatic decoder_status_t apply_byte(input logic [7:0] value);
		logic executed;
		executed = 1'b0;
		if (value == CH_CR || value == CH_LF) begin
			evaluate_command_line();
			executed = 1'b1;
		end else if (value == CH_BS) begin
			if (line_fill > 0) line_fill--;
		end else begin
			if (line_fill < LINE_LENGTH) begin
				line_buf[line_fill] = value;
				line_fill++;
			end
			if (line_fill >= LINE_LENGTH) begin
				evaluate_command_line();
				executed = 1'b1;
			end
		end
		return '{dbg_flag, relay_lvl, pwm_lvl, executed};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		decoder_status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				report_mismatch("result word with no byte outstanding");
			end else begin
				want = expected_status.pop_front();
				if (debug_on !== want.dbg)
					report_mismatch($sformatf("debug_on %b, want %b", debug_on, want.dbg));
				if (relay_on !== want.relay)
					report_mismatch($sformatf("relay_on %b, want %b", relay_on, want.relay));
				if (pwm_enable_on !== want.pwm)
					report_mismatch($sformatf("pwm_enable_on %b, want %b",
						pwm_enable_on, want.pwm));
				if (line_executed !== want.executed)
					report_mismatch($sformatf("line_executed %b, want %b",
						line_executed, want.executed));
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= value;
		do @(posedge clk); while (!in_ready);
		expected_status.push_back(apply_byte(value));
	endtask

	function automatic void add_text(input string s);
		for (int j = 0; j < s.len(); j++) line_bytes.push_back(s[j]);
	endfunction

	function automatic void add_spaces(input int n);
		repeat (n) line_bytes.push_back(CH_SP);
	endfunction

	function automatic void pad_to_full();
		while (line_bytes.size() < LINE_LENGTH) line_bytes.push_back(CH_SP);
	endfunction

	function automatic logic [7:0] random_end();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	task automatic send_line();
		foreach (line_bytes[j]) send_byte(line_bytes[j]);
		line_bytes.delete();
	endtask

	function automatic void build_random_line();
		int n;
		line_bytes.delete();
		if ($urandom_range(0, 99) < 25) begin
			n = $urandom_range(0, 40);
			repeat (n) begin
				if ($urandom_range(0, 4) == 0) line_bytes.push_back(CH_BS);
				else line_bytes.push_back(8'($urandom_range(0, 255)));
			end
			line_bytes.push_back(random_end());
			return;
		end
		add_spaces($urandom_range(0, 2));
		case ($urandom_range(0, 7))
			0, 1, 2: add_text("debug");
			3, 4:    add_text("relay");
			5, 6:    add_text("pwm");
			default: begin
				if ($urandom_range(0, 1)) add_text("relays");
				else add_text("pw");
			end
		endcase
		if ($urandom_range(0, 9) == 0) begin
			line_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
			line_bytes.push_back(CH_BS);
		end
		if ($urandom_range(0, 11) == 0) line_bytes.push_back(CH_NUL);
		if ($urandom_range(0, 9) != 0) begin
			add_spaces($urandom_range(1, 3));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: add_text("on");
				4, 5, 6, 7: add_text("off");
				8:          add_text("of");
				default:    add_text("onn");
			endcase
		end
		if ($urandom_range(0, 7) == 0) add_text(" x");
		add_spaces($urandom_range(0, 2));
		if ($urandom_range(0, 9) == 0) pad_to_full();
		else line_bytes.push_back(random_end());
	endfunction

	task automatic set_idle(input int sender_pct, input int receiver_pct);
		idle_pct  = sender_pct;
		stall_pct = receiver_pct;
	endtask

	task automatic test_directed();
		send_byte(CH_BS);
		add_text("debug onx");
		line_bytes.push_back(CH_BS);
		line_bytes.push_back(CH_LF);
		line_bytes.push_back(CH_NUL);
		line_bytes.push_back(8'hff);
		line_bytes.push_back(CH_CR);
		add_text("pwm");
		line_bytes.push_back(CH_CR);
		add_text(" pwm  on x");
		line_bytes.push_back(CH_LF);
		send_line();
	endtask

	task automatic test_full_line();
		add_text("debug off");
		pad_to_full();
		send_line();
		add_text("  relay on");
		pad_to_full();
		send_line();
	endtask

	task automatic test_random(input int byte_budget);
		int sent;
		sent = 0;
		while (sent < byte_budget) begin
			build_random_line();
			sent += line_bytes.size();
			send_line();
		end
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		add_text("debug on");
		line_bytes.push_back(CH_CR);
		add_text("relay on");
		line_bytes.push_back(CH_LF);
		add_text("pwm on");
		line_bytes.push_back(CH_CR);
		send_line();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (48) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(0, 0);
		test_directed();
		test_full_line();
		test_random(90);
		set_idle(76, 0);
		test_random(90);
		set_idle(0, 76);
		test_backpressure();
		test_random(90);
		set_idle(27, 27);
		test_random(90);
		drain_results();
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
